>>> src/mrc_pkg.sv
// shared types, constants and the crc-16 byte update for the modbus rtu response checker
// no dependencies; imported by every module of the block
package mrc_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  EXC_BIT       = 8'h80;
	localparam logic [7:0]  FC_READ_INPUT = 8'h04;
	localparam logic [7:0]  DATA_LEN      = 8'h04;

	localparam logic [7:0]  MIN_FRAME_LEN  = 8'd5;
	localparam logic [7:0]  FULL_FRAME_LEN = 8'd9;
	localparam logic [7:0]  COUNT_MAX      = 8'd255;
	localparam logic [7:0]  HDR_LEN        = 8'd3;
	localparam logic [7:0]  DATA_END       = 8'd7;
	localparam logic [7:0]  CRC_START      = 8'd2;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION = 2'd1;

	localparam logic [7:0] RST_SLAVE_ID = 8'd1;
	localparam logic [7:0] RST_FUNCTION = 8'd4;

	localparam logic [2:0] ST_VALID     = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_ID    = 3'd2;
	localparam logic [2:0] ST_BAD_CRC   = 3'd3;
	localparam logic [2:0] ST_EXCEPTION = 3'd4;
	localparam logic [2:0] ST_BAD_FUNC  = 3'd5;
	localparam logic [2:0] ST_BAD_DATA  = 3'd6;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  exc;
		logic [31:0] value;
	} result_t;

	// reflected crc-16, one byte, eight shift steps unrolled
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/mrc_frame_core.sv
// per-frame state of the checker: running crc, byte count, header, data word, crc delay line
// and the frame-end verdict; uses mrc_pkg
module mrc_frame_core
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_in,
	input  logic        eof_in,
	input  logic [7:0]  slave_id,
	input  logic [7:0]  function_code,
	output result_t     result
);

	logic [15:0] crc_q;
	logic [7:0]  count_q;
	logic [7:0]  hdr_q [3];
	logic [31:0] data_q;
	logic [7:0]  pend_q [2];

	logic [15:0] crc_n;
	logic [7:0]  count_n;
	logic [7:0]  hdr_n [3];
	logic [31:0] data_n;
	logic [15:0] rx_crc;

	always_comb begin
		crc_n = (count_q >= CRC_START) ? crc_fold(crc_q, pend_q[0]) : crc_q;
		count_n = (count_q < COUNT_MAX) ? count_q + 8'd1 : count_q;
		hdr_n = hdr_q;
		data_n = data_q;
		if (count_q < HDR_LEN) begin
			hdr_n[count_q[1:0]] = byte_in;
		end else if (count_q < DATA_END) begin
			data_n = {data_q[23:0], byte_in};
		end
		// last two bytes of the frame carry the crc, low byte first
		rx_crc = {byte_in, pend_q[1]};
	end

	always_comb begin
		result.status = ST_VALID;
		result.exc    = 8'h00;
		result.value  = 32'h0;
		if (count_n < MIN_FRAME_LEN) begin
			result.status = ST_SHORT;
		end else if (hdr_n[0] != slave_id) begin
			result.status = ST_BAD_ID;
		end else if (rx_crc != crc_n) begin
			result.status = ST_BAD_CRC;
		end else if ((hdr_n[1] & EXC_BIT) != 8'h00) begin
			result.status = ST_EXCEPTION;
			result.exc    = hdr_n[2];
		end else if (hdr_n[1] != function_code || hdr_n[1] != FC_READ_INPUT) begin
			result.status = ST_BAD_FUNC;
		end else if (hdr_n[2] != DATA_LEN || count_n < FULL_FRAME_LEN) begin
			result.status = ST_BAD_DATA;
		end else begin
			result.value = data_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= 8'd0;
			hdr_q   <= '{default: 8'h00};
			data_q  <= 32'h0;
			pend_q  <= '{default: 8'h00};
		end else if (fire) begin
			if (eof_in) begin
				crc_q   <= CRC_INIT;
				count_q <= 8'd0;
				hdr_q   <= '{default: 8'h00};
				data_q  <= 32'h0;
				pend_q  <= '{default: 8'h00};
			end else begin
				crc_q     <= crc_n;
				count_q   <= count_n;
				hdr_q     <= hdr_n;
				data_q    <= data_n;
				pend_q[0] <= pend_q[1];
				pend_q[1] <= byte_in;
			end
		end
	end

endmodule

>>> src/modbus_rtu_response_checker.sv
// channel  | signals                                        | accepted when
// request  | in_valid, in_ready, rx_byte, end_of_frame      | in_valid && in_ready
// result   | out_valid, out_ready, frame_status, exception_code, value_bits
//          |                                                | out_valid && out_ready
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | cfg_valid && cfg_ready
//
// one request per cycle unless an end-of-frame request meets a stalled result; a request
// goes via the input register and the combinational crc/check stage to the result register
// only requests with end_of_frame produce a result; the others update frame state only
// a stalled result holds the check stage for end-of-frame requests only
// reset returns the crc to 0xffff, clears the frame and loads slave id 1, function 4
// top level of the checker; uses mrc_pkg and mrc_frame_core
module modbus_rtu_response_checker
	import mrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 end_of_frame,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           frame_status,
	output logic [7:0]           exception_code,
	output logic [31:0]          value_bits,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_n;
	logic [7:0]  slave_id_q;
	logic [7:0]  function_q;
	logic        advance;

	assign advance   = vld_s1 && (!eof_s1 || !out_valid_q || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= RST_SLAVE_ID;
			function_q <= RST_FUNCTION;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SLAVE_ID: slave_id_q <= cfg_data;
				CFG_FUNCTION: function_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			eof_s1  <= end_of_frame;
		end
	end

	mrc_frame_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.byte_in       (byte_s1),
		.eof_in        (eof_s1),
		.slave_id      (slave_id_q),
		.function_code (function_q),
		.result        (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			res_q <= res_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_status   = res_q.status;
	assign exception_code = res_q.exc;
	assign value_bits     = res_q.value;

endmodule

>>> src/mrc_checker.sv
// port-level checks on the modbus rtu response checker
// uses mrc_pkg; bound to modbus_rtu_response_checker below
module mrc_checker
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  frame_status,
	input  logic [7:0]  exception_code,
	input  logic [31:0] value_bits
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_status)
			&& $stable(exception_code) && $stable(value_bits))
		else $error("result changed while stalled");

	a_value_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != ST_VALID |-> value_bits == 32'h0)
		else $error("value bits on a rejected frame");

	a_exc_only_exception: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != ST_EXCEPTION |-> exception_code == 8'h00)
		else $error("exception code without exception status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status != 3'd7)
		else $error("undefined frame status");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.frame_status   (frame_status),
	.exception_code (exception_code),
	.value_bits     (value_bits)
);

>>> tb/modbus_rtu_response_checker_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for modbus_rtu_response_checker: byte driver, result monitor and a
// frame-level predictor (crc-16, header and data capture, status priority)
// depends on mrc_pkg and the checker rtl
module modbus_rtu_response_checker_tb;
	import mrc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = '0;
	logic                 end_of_frame = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           frame_status;
	logic [7:0]           exception_code;
	logic [31:0]          value_bits;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	modbus_rtu_response_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_status(frame_status),
		.exception_code(exception_code),
		.value_bits(value_bits),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and the frame state
	logic [7:0]  want_slave_id = RST_SLAVE_ID;
	logic [7:0]  want_function = RST_FUNCTION;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  frame_len = '0;
	logic [7:0]  hdr [0:2] = '{8'h00, 8'h00, 8'h00};
	logic [31:0] data_acc = '0;
	logic [7:0]  crc_delay [0:1] = '{8'h00, 8'h00};

	rx_item_t    rx_items[$];
	result_t     pending_results[$];
	logic [7:0]  frame_buf[$];

	bit          no_idle = 1'b0;
	bit          in_taken = 1'b0;
	int          bytes_queued = 0;
	int          bytes_sent = 0;
	int          results_checked = 0;
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          status_seen [0:7] = '{0, 0, 0, 0, 0, 0, 0, 0};

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255, 0));
	endfunction

	// advance the frame state by one byte; on the last byte return the frame verdict
	task automatic frame_check_step(input logic [7:0] b, input logic last, output bit done,
			output result_t res);
		logic [15:0] rx_crc;
		res = '0;
		done = 1'b0;
		// the two newest bytes are held back: they may be the crc itself
		if (frame_len >= CRC_START) crc_acc = crc16_byte(crc_acc, crc_delay[0]);
		crc_delay[0] = crc_delay[1];
		crc_delay[1] = b;
		if (frame_len < HDR_LEN) hdr[frame_len] = b;
		else if (frame_len < DATA_END) data_acc = {data_acc[23:0], b};
		if (frame_len != COUNT_MAX) frame_len = frame_len + 8'd1;
		if (last) begin
			done = 1'b1;
			rx_crc = {crc_delay[1], crc_delay[0]};
			if (frame_len < MIN_FRAME_LEN) begin
				res.status = ST_SHORT;
			end else if (hdr[0] != want_slave_id) begin
				res.status = ST_BAD_ID;
			end else if (rx_crc != crc_acc) begin
				res.status = ST_BAD_CRC;
			end else if ((hdr[1] & EXC_BIT) != 8'h00) begin
				res.status = ST_EXCEPTION;
				res.exc = hdr[2];
			end else if (hdr[1] != want_function || hdr[1] != FC_READ_INPUT) begin
				res.status = ST_BAD_FUNC;
			end else if (hdr[2] != DATA_LEN || frame_len < FULL_FRAME_LEN) begin
				res.status = ST_BAD_DATA;
			end else begin
				res.status = ST_VALID;
				res.value = data_acc;
			end
			crc_acc = CRC_INIT;
			frame_len = '0;
			hdr = '{8'h00, 8'h00, 8'h00};
			data_acc = '0;
			crc_delay = '{8'h00, 8'h00};
		end
	endtask

	// request driver
	always @(negedge clk) begin : byte_driver
		rx_item_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (rx_items.size() > 0 && (no_idle || $urandom_range(99, 0) >= 33)) begin
					nxt = rx_items.pop_front();
					in_valid <= 1'b1;
					rx_byte <= nxt.data;
					end_of_frame <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= no_idle || $urandom_range(99, 0) >= 33;
		end
	end

	// request monitor, prediction and result check
	always @(posedge clk) begin : result_monitor
		result_t want;
		bit      done;
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			bytes_sent++;
			frame_check_step(rx_byte, end_of_frame, done, want);
			if (done) pending_results.push_back(want);
		end
		if (out_valid && out_ready) begin
			results_checked++;
			status_seen[frame_status]++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: frame_status %0d exception_code %0h value_bits %08h",
					frame_status, exception_code, value_bits);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (frame_status !== want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status, frame_status);
					fail_count++;
				end
				if (exception_code !== want.exc) begin
					$error("exception_code: expected %02h, got %02h", want.exc, exception_code);
					fail_count++;
				end
				if (value_bits !== want.value) begin
					$error("value_bits: expected %08h, got %08h", want.value, value_bits);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == CFG_SLAVE_ID) want_slave_id = val;
		else if (idx == CFG_FUNCTION) want_function = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// every queued byte sent, every result back, then let the pipeline empty
	task automatic wait_idle();
		while (rx_items.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic start_frame(input logic [7:0] id, input logic [7:0] fc, input logic [7:0] cnt);
		frame_buf.delete();
		frame_buf.push_back(id);
		frame_buf.push_back(fc);
		frame_buf.push_back(cnt);
	endtask

	task automatic add_random_bytes(input int n);
		repeat (n) frame_buf.push_back(rand_byte());
	endtask

	task automatic queue_frame(input bit add_crc, input bit corrupt);
		logic [15:0] crc;
		int          pos;
		rx_item_t    it;
		if (add_crc) begin
			crc = CRC_INIT;
			foreach (frame_buf[i]) crc = crc16_byte(crc, frame_buf[i]);
			frame_buf.push_back(crc[7:0]);
			frame_buf.push_back(crc[15:8]);
		end
		if (corrupt) begin
			pos = int'($urandom_range(frame_buf.size() - 1, 0));
			frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(255, 1));
		end
		foreach (frame_buf[i]) begin
			it.data = frame_buf[i];
			it.last = (i == frame_buf.size() - 1);
			rx_items.push_back(it);
		end
		bytes_queued += frame_buf.size();
		frame_buf.delete();
	endtask

	task automatic queue_random_frame();
		int         pick;
		logic [7:0] cnt;
		pick = int'($urandom_range(99, 0));
		if (pick < 60) begin
			// read response, now and then padded past the data word
			start_frame(want_slave_id, FC_READ_INPUT, DATA_LEN);
			add_random_bytes(4 + (($urandom_range(9, 0) == 0) ? $urandom_range(6, 1) : 0));
			queue_frame(1'b1, pick >= 45);
		end else if (pick < 72) begin
			start_frame(want_slave_id, EXC_BIT | rand_byte(), rand_byte());
			queue_frame(1'b1, 1'b0);
		end else if (pick < 77) begin
			start_frame(want_slave_id ^ 8'($urandom_range(255, 1)), FC_READ_INPUT, DATA_LEN);
			add_random_bytes(4);
			queue_frame(1'b1, 1'b0);
		end else if (pick < 83) begin
			start_frame(want_slave_id, $urandom_range(1, 0) ? want_function
				: (rand_byte() & ~EXC_BIT), DATA_LEN);
			add_random_bytes(4);
			queue_frame(1'b1, 1'b0);
		end else if (pick < 90) begin
			// wrong byte count, or a data word cut short
			if ($urandom_range(1, 0)) begin
				cnt = rand_byte();
				if (cnt == DATA_LEN) cnt = cnt ^ 8'h01;
				start_frame(want_slave_id, FC_READ_INPUT, cnt);
				add_random_bytes(4);
			end else begin
				start_frame(want_slave_id, FC_READ_INPUT, DATA_LEN);
				add_random_bytes($urandom_range(3, 0));
			end
			queue_frame(1'b1, 1'b0);
		end else if (pick < 95) begin
			frame_buf.delete();
			add_random_bytes($urandom_range(4, 1));
			queue_frame(1'b0, 1'b0);
		end else begin
			frame_buf.delete();
			add_random_bytes($urandom_range(12, 1));
			queue_frame(1'b0, 1'b0);
		end
	endtask

	task automatic queue_random_until(input int target);
		while (bytes_queued < target) queue_random_frame();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames under the reset register values
		frame_buf.delete();
		frame_buf.push_back(8'hFF);
		queue_frame(1'b0, 1'b0);
		start_frame(RST_SLAVE_ID, FC_READ_INPUT, DATA_LEN);
		frame_buf.push_back(8'hFF);
		queue_frame(1'b0, 1'b0);
		start_frame(RST_SLAVE_ID, FC_READ_INPUT, DATA_LEN);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h00);
		queue_frame(1'b1, 1'b0);
		start_frame(RST_SLAVE_ID, EXC_BIT | FC_READ_INPUT, 8'h02);
		queue_frame(1'b1, 1'b0);
		start_frame(8'hFF, FC_READ_INPUT, DATA_LEN);
		queue_frame(1'b1, 1'b0);
		wait_idle();

		// broadcast address, no backpressure on either side
		write_reg(CFG_SLAVE_ID, 8'h00);
		write_reg(CFG_FUNCTION, FC_READ_INPUT);
		no_idle = 1'b1;
		queue_random_until(bytes_queued + 150);
		wait_idle();
		no_idle = 1'b0;

		// extreme register values: no frame can pass the function check
		write_reg(CFG_SLAVE_ID, 8'hFF);
		write_reg(CFG_FUNCTION, 8'h00);
		queue_random_until(bytes_queued + 80);
		wait_idle();

		write_reg(CFG_SLAVE_ID, 8'($urandom_range(254, 2)));
		write_reg(CFG_FUNCTION, 8'hFF);
		queue_random_until(bytes_queued + 80);
		wait_idle();

		write_reg(CFG_SLAVE_ID, rand_byte());
		write_reg(CFG_FUNCTION, FC_READ_INPUT);
		queue_random_until(bytes_queued + 100);
		// sender holds off until every result is back
		wait_idle();
		// oversize frame: length counter saturates while the crc keeps running
		start_frame(want_slave_id, FC_READ_INPUT, DATA_LEN);
		add_random_bytes($urandom_range(270, 256));
		queue_frame(1'b1, 1'b0);
		queue_random_until(bytes_queued + 100);
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d frame results never arrived", pending_results.size());
			fail_count++;
		end
		$display("sent %0d bytes, checked %0d frame results over 5 register settings",
			bytes_sent, results_checked);
		$display("status mix: valid %0d short %0d id %0d crc %0d exc %0d func %0d data %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5], status_seen[6]);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> modbus_rtu_response_checker.f
src/mrc_pkg.sv
src/mrc_frame_core.sv
src/modbus_rtu_response_checker.sv
src/mrc_checker.sv
tb/modbus_rtu_response_checker_tb.sv
